// ===== sv/fbsg_pkg.sv =====
// Shared types and constants for the FAT boot sector geometry unit.
// No dependencies; every other file imports this package.
package fbsg_pkg;

  // Boot sector byte offsets
  localparam int OFF_BPS_LO    = 'h0b;
  localparam int OFF_BPS_HI    = 'h0c;
  localparam int OFF_SPC       = 'h0d;
  localparam int OFF_RSV_LO    = 'h0e;
  localparam int OFF_RSV_HI    = 'h0f;
  localparam int OFF_COPIES    = 'h10;
  localparam int OFF_ROOT_LO   = 'h11;
  localparam int OFF_ROOT_HI   = 'h12;
  localparam int OFF_SPF_LO    = 'h16;
  localparam int OFF_SPF_HI    = 'h17;
  localparam int OFF_SHORT_SIG = 'h36;
  localparam int OFF_LONG_SIG  = 'h52;

  // Signature text "FAT1" + digit and "FAT32"
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_1 = 8'h31;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] CH_3 = 8'h33;
  localparam logic [7:0] CH_6 = 8'h36;

  // Result codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_SIG   = 2'd1;
  localparam logic [1:0] STAT_ZERO_BPS = 2'd2;

  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_FAT12   = 2'd1;
  localparam logic [1:0] KIND_FAT16   = 2'd2;
  localparam logic [1:0] KIND_FAT32   = 2'd3;

  // Cluster caps
  localparam logic [15:0] FAT12_LIMIT = 16'h0ff7;
  localparam logic [15:0] FAT12_CAP   = 16'h0ff6;
  localparam logic [30:0] FAT16_LIMIT = 31'h0000fff7;
  localparam logic [15:0] FAT16_CAP   = 16'hfff6;
  // fat_bytes/3*2 >= 0xff7  <=>  fat_bytes >= 3*ceil(0xff7/2)
  localparam logic [31:0] FAT12_CAP_BYTES = 32'(3 * ((int'(FAT12_LIMIT) + 1) / 2));
  // x/3 == (x*0xaaab) >> 17 for any 16-bit x
  localparam logic [15:0] RECIP3 = 16'haaab;

  localparam int DIVN_W = 22;  // entries*32 + bps - 1

  typedef struct packed {
    logic [7:0] sector_byte;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  fat_kind;
    logic [15:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] root_entry_count;
    logic [15:0] fat_start_sector;
    logic [15:0] sectors_per_fat_table;
    logic [7:0]  fat_copies;
    logic [23:0] root_dir_sector;
    logic [31:0] cluster0_sector;
    logic [15:0] max_cluster;
  } result_t;

  // One classified sector handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] bps;
    logic [7:0]  spc;
    logic [15:0] entries;
    logic [15:0] reserved;
    logic [15:0] spf;
    logic [7:0]  copies;
  } job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_FIN
  } back_state_t;

endpackage

// ===== sv/fbsg_front.sv =====
// Front end: byte counter, parameter-block capture and signature classification.
// Depends on fbsg_pkg.
module fbsg_front import fbsg_pkg::*; #(
  parameter int SECTOR_BYTES = 512
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t item,
  input  q_stat_t  q_stat,
  output logic     job_push,
  output job_t     job
);

  localparam int CNT_W = $clog2(SECTOR_BYTES);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SECTOR_BYTES - 1);

  logic [CNT_W-1:0] byte_count;
  logic [15:0] bps, rsv, entries, spf;
  logic [7:0]  spc, copies, digit;
  logic        short_ok, long_ok;

  logic [CNT_W-1:0] idx;
  logic [15:0] bps_next, rsv_next, entries_next, spf_next;
  logic [7:0]  spc_next, copies_next, digit_next;
  logic        short_ok_next, long_ok_next;
  logic        accept;
  logic [7:0]  b;

  assign accept = push && !q_stat.full;
  assign b      = item.sector_byte;

  always_comb begin
    idx = item.start_req ? '0 : byte_count;
    if (idx == '0) begin
      bps_next = '0; rsv_next = '0; entries_next = '0; spf_next = '0;
      spc_next = '0; copies_next = '0; digit_next = '0;
      short_ok_next = 1'b1; long_ok_next = 1'b1;
    end else begin
      bps_next = bps; rsv_next = rsv; entries_next = entries; spf_next = spf;
      spc_next = spc; copies_next = copies; digit_next = digit;
      short_ok_next = short_ok; long_ok_next = long_ok;
    end
    unique case (idx)
      CNT_W'(OFF_BPS_LO):      bps_next[7:0]      = b;
      CNT_W'(OFF_BPS_HI):      bps_next[15:8]     = b;
      CNT_W'(OFF_SPC):         spc_next           = b;
      CNT_W'(OFF_RSV_LO):      rsv_next[7:0]      = b;
      CNT_W'(OFF_RSV_HI):      rsv_next[15:8]     = b;
      CNT_W'(OFF_COPIES):      copies_next        = b;
      CNT_W'(OFF_ROOT_LO):     entries_next[7:0]  = b;
      CNT_W'(OFF_ROOT_HI):     entries_next[15:8] = b;
      CNT_W'(OFF_SPF_LO):      spf_next[7:0]      = b;
      CNT_W'(OFF_SPF_HI):      spf_next[15:8]     = b;
      CNT_W'(OFF_SHORT_SIG):   if (b != CH_F) short_ok_next = 1'b0;
      CNT_W'(OFF_SHORT_SIG+1): if (b != CH_A) short_ok_next = 1'b0;
      CNT_W'(OFF_SHORT_SIG+2): if (b != CH_T) short_ok_next = 1'b0;
      CNT_W'(OFF_SHORT_SIG+3): if (b != CH_1) short_ok_next = 1'b0;
      CNT_W'(OFF_SHORT_SIG+4): digit_next = b;
      CNT_W'(OFF_LONG_SIG):    if (b != CH_F) long_ok_next = 1'b0;
      CNT_W'(OFF_LONG_SIG+1):  if (b != CH_A) long_ok_next = 1'b0;
      CNT_W'(OFF_LONG_SIG+2):  if (b != CH_T) long_ok_next = 1'b0;
      CNT_W'(OFF_LONG_SIG+3):  if (b != CH_3) long_ok_next = 1'b0;
      CNT_W'(OFF_LONG_SIG+4):  if (b != CH_2) long_ok_next = 1'b0;
      default: ;
    endcase

    // "FAT1" wins over "FAT32" even when its digit is bad
    if (short_ok_next) begin
      if (digit_next == CH_2)      job.kind = KIND_FAT12;
      else if (digit_next == CH_6) job.kind = KIND_FAT16;
      else                         job.kind = KIND_UNKNOWN;
    end else if (long_ok_next) begin
      job.kind = KIND_FAT32;
    end else begin
      job.kind = KIND_UNKNOWN;
    end
    job.bps      = bps_next;
    job.spc      = spc_next;
    job.entries  = entries_next;
    job.reserved = rsv_next;
    job.spf      = spf_next;
    job.copies   = copies_next;
  end

  assign job_push = accept && (idx == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      bps <= '0; rsv <= '0; entries <= '0; spf <= '0;
      spc <= '0; copies <= '0; digit <= '0;
      short_ok <= 1'b1; long_ok <= 1'b1;
    end else if (accept) begin
      byte_count <= (idx == LAST) ? '0 : idx + 1'b1;
      bps <= bps_next; rsv <= rsv_next; entries <= entries_next; spf <= spf_next;
      spc <= spc_next; copies <= copies_next; digit <= digit_next;
      short_ok <= short_ok_next; long_ok <= long_ok_next;
    end
  end

endmodule

// ===== sv/fbsg_queue.sv =====
// Two-entry job queue between front and back.
// Depends on fbsg_pkg.
module fbsg_queue import fbsg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    din,
  input  logic    pop,
  output job_t    dout,
  output q_stat_t stat
);

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign dout       = mem[rd_ptr];
  assign stat.valid = (count != 2'd0);
  assign stat.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/fbsg_back.sv =====
// Back end: geometry arithmetic with a bit-serial divider and a result register.
// Depends on fbsg_pkg.
module fbsg_back import fbsg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  job_t    job,
  input  q_stat_t q_stat,
  output logic    job_pop,
  input  logic    pop,
  output logic    out_valid,
  output result_t result
);

  localparam int STEP_W = $clog2(DIVN_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVN_W - 1);

  back_state_t state, state_next;
  job_t        cur;
  logic [DIVN_W-1:0] quo;
  logic [16:0]       rem;
  logic [STEP_W-1:0] step;
  logic [23:0]       root;
  logic [31:0]       fat_bytes;
  logic              out_load;

  logic [16:0]       rem_sh;
  logic              ge;
  logic [DIVN_W-1:0] dividend;
  logic [28:0]       prod3;
  logic [30:0]       half;
  result_t           res_next;

  assign rem_sh   = {rem[15:0], quo[DIVN_W-1]};
  assign ge       = rem_sh >= {1'b0, cur.bps};
  // ceil(entries*32 / bps) numerator; bps == 0 is masked at the end
  assign dividend = {1'b0, job.entries, 5'b0} + {6'b0, job.bps} - DIVN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_stat.valid) begin
          job_pop    = 1'b1;
          state_next = BK_MUL;
        end
      end
      BK_MUL: state_next = BK_DIV;
      BK_DIV: if (step == LAST_STEP) state_next = BK_FIN;
      BK_FIN: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        cur <= job;
        quo <= dividend;
      end
      BK_MUL: begin
        root      <= {8'b0, cur.reserved} + 24'(cur.spf * cur.copies);
        fat_bytes <= cur.spf * cur.bps;
        rem       <= '0;
        step      <= '0;
      end
      BK_DIV: begin
        rem  <= ge ? rem_sh - {1'b0, cur.bps} : rem_sh;
        quo  <= {quo[DIVN_W-2:0], ge};
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    prod3    = fat_bytes[12:0] * RECIP3;
    half     = fat_bytes[31:1];
    res_next = '0;
    if (cur.kind == KIND_UNKNOWN) begin
      res_next.status = STAT_NO_SIG;
    end else begin
      res_next.fat_kind = cur.kind;
      if (cur.kind != KIND_FAT32) begin
        res_next.bytes_per_sector      = cur.bps;
        res_next.sectors_per_cluster   = cur.spc;
        res_next.root_entry_count      = cur.entries;
        res_next.fat_start_sector      = cur.reserved;
        res_next.sectors_per_fat_table = cur.spf;
        res_next.fat_copies            = cur.copies;
        res_next.root_dir_sector       = root;
        if (cur.bps == '0) begin
          res_next.status = STAT_ZERO_BPS;
        end else begin
          res_next.cluster0_sector = {8'b0, root} + {10'b0, quo} - {23'b0, cur.spc, 1'b0};
          if (cur.kind == KIND_FAT12) begin
            res_next.max_cluster = (fat_bytes >= FAT12_CAP_BYTES) ? FAT12_CAP
                                                                  : {3'b0, prod3[28:17], 1'b0};
          end else begin
            res_next.max_cluster = (half >= FAT16_LIMIT) ? FAT16_CAP : half[15:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst)           out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (pop)      out_valid <= 1'b0;
  end

endmodule

// ===== sv/fat_boot_sector_geometry_unit.sv =====
// Top level of the FAT boot sector geometry unit: front, job queue, back.
// Depends on fbsg_pkg, fbsg_front, fbsg_queue and fbsg_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------
//   input    | push / full        | item   (in_item_t: byte, start)
//   result   | pop / empty        | result (result_t: geometry word)
//
// Bytes are taken one per cycle; full rises only when two finished sectors
// are queued and the back end has not started on either.
// Each sector's result takes one load, one multiply, 22 steps of the bit-serial
// root-sector divider and a finish state that waits while a result is unpopped.
// A waiting result stalls the back end; the queue keeps the front going until it fills.
// Reset (rst, synchronous) clears the byte count, capture, queue and result valid flag.
module fat_boot_sector_geometry_unit import fbsg_pkg::*; #(
  parameter int SECTOR_BYTES = 512
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     empty,
  input  logic     pop,
  output result_t  result
);

  job_t    f_job, q_job;
  logic    job_push, job_pop, out_valid;
  q_stat_t q_stat;

  // Front: counts bytes, captures the parameter block, classifies the type
  fbsg_front #(.SECTOR_BYTES(SECTOR_BYTES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .q_stat   (q_stat),
    .job_push (job_push),
    .job      (f_job)
  );

  // Two sectors of slack between classification and arithmetic
  fbsg_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (job_push),
    .din  (f_job),
    .pop  (job_pop),
    .dout (q_job),
    .stat (q_stat)
  );

  // Back: root/cluster-0 sectors and cluster cap, holds the result word
  fbsg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_job),
    .q_stat    (q_stat),
    .job_pop   (job_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .result    (result)
  );

  assign full  = q_stat.full;
  assign empty = !out_valid;

  // A finished sector never lands on a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !q_stat.full)
    else $error("job queue overflow");

  // Back end only pulls from a non-empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> q_stat.valid)
    else $error("job queue underflow");

  // Missing signature reports no type and no geometry
  a_nosig_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == STAT_NO_SIG) |->
      (result.fat_kind == KIND_UNKNOWN && result.root_dir_sector == '0))
    else $error("no-signature result carries data");

  // FAT12 cap holds
  a_fat12_cap: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.fat_kind == KIND_FAT12) |-> (result.max_cluster <= FAT12_CAP))
    else $error("FAT12 max cluster above cap");

endmodule

// ===== sim/fbsg_checker.sv =====
// Checker for the FAT boot sector geometry unit: watches the input and result ports,
// predicts each sector's geometry word and compares it field by field.
// Depends on fbsg_pkg.
module fbsg_checker import fbsg_pkg::*; #(
  parameter int SECTOR_BYTES = 512
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  logic     full,
  input  in_item_t item,
  input  logic     empty,
  input  logic     pop,
  input  result_t  result,
  output int       fail_count,
  output int       waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] FAT1_TEXT  = {CH_F, CH_A, CH_T, CH_1};
  localparam logic [39:0] FAT32_TEXT = {CH_F, CH_A, CH_T, CH_3, CH_2};

  int unsigned byte_pos;
  logic [15:0] bps_q, rsv_q, ents_q, spf_q;
  logic [7:0]  spc_q, copies_q, digit_q;
  logic        fat1_ok, fat32_ok;
  result_t     geometry_q[$];

  task automatic clear_fields();
    bps_q    = '0;
    rsv_q    = '0;
    ents_q   = '0;
    spf_q    = '0;
    spc_q    = '0;
    copies_q = '0;
    digit_q  = '0;
    fat1_ok  = 1'b1;
    fat32_ok = 1'b1;
  endtask

  function automatic result_t sector_geometry();
    result_t     r;
    logic [1:0]  kind;
    logic [31:0] root, root_secs;
    logic [63:0] fat_bytes, top;
    r = '0;
    kind = KIND_UNKNOWN;
    if (fat1_ok) begin
      if (digit_q == CH_2) kind = KIND_FAT12;
      else if (digit_q == CH_6) kind = KIND_FAT16;
    end else if (fat32_ok) begin
      kind = KIND_FAT32;
    end
    if (kind == KIND_UNKNOWN) begin
      r.status = STAT_NO_SIG;
      return r;
    end
    r.status   = STAT_OK;
    r.fat_kind = kind;
    if (kind == KIND_FAT32) return r;

    root = 32'(rsv_q) + 32'(spf_q) * 32'(copies_q);
    r.bytes_per_sector      = bps_q;
    r.sectors_per_cluster   = spc_q;
    r.root_entry_count      = ents_q;
    r.fat_start_sector      = rsv_q;
    r.sectors_per_fat_table = spf_q;
    r.fat_copies            = copies_q;
    r.root_dir_sector       = root[23:0];
    if (bps_q == 16'd0) begin
      r.status = STAT_ZERO_BPS;
      return r;
    end
    // root directory sectors, rounded up; cluster 2 is the first data cluster
    root_secs = (32'(ents_q) * 32'd32 + 32'(bps_q) - 32'd1) / 32'(bps_q);
    r.cluster0_sector = root + root_secs - 32'd2 * 32'(spc_q);
    fat_bytes = 64'(spf_q) * 64'(bps_q);
    if (kind == KIND_FAT12) begin
      top = fat_bytes / 64'd3 * 64'd2;
      if (top >= 64'(FAT12_LIMIT)) top = 64'(FAT12_CAP);
    end else begin
      top = fat_bytes / 64'd2;
      if (top >= 64'(FAT16_LIMIT)) top = 64'(FAT16_CAP);
    end
    r.max_cluster = top[15:0];
    return r;
  endfunction

  task automatic take_byte(in_item_t it);
    int unsigned idx, k;
    logic [7:0]  b;
    b = it.sector_byte;
    idx = it.start_req ? 0 : byte_pos;
    if (idx >= SECTOR_BYTES) idx = 0;
    if (idx == 0) clear_fields();
    case (idx)
      OFF_BPS_LO:  bps_q[7:0]   = b;
      OFF_BPS_HI:  bps_q[15:8]  = b;
      OFF_SPC:     spc_q        = b;
      OFF_RSV_LO:  rsv_q[7:0]   = b;
      OFF_RSV_HI:  rsv_q[15:8]  = b;
      OFF_COPIES:  copies_q     = b;
      OFF_ROOT_LO: ents_q[7:0]  = b;
      OFF_ROOT_HI: ents_q[15:8] = b;
      OFF_SPF_LO:  spf_q[7:0]   = b;
      OFF_SPF_HI:  spf_q[15:8]  = b;
      default: ;
    endcase
    if (idx >= OFF_SHORT_SIG && idx < OFF_SHORT_SIG + 4) begin
      k = idx - OFF_SHORT_SIG;
      if (b != FAT1_TEXT[8 * (3 - k) +: 8]) fat1_ok = 1'b0;
    end
    if (idx == OFF_SHORT_SIG + 4) digit_q = b;
    if (idx >= OFF_LONG_SIG && idx < OFF_LONG_SIG + 5) begin
      k = idx - OFF_LONG_SIG;
      if (b != FAT32_TEXT[8 * (4 - k) +: 8]) fat32_ok = 1'b0;
    end
    if (idx == SECTOR_BYTES - 1) begin
      byte_pos = 0;
      geometry_q.push_back(sector_geometry());
    end else begin
      byte_pos = idx + 1;
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      byte_pos = 0;
      clear_fields();
      geometry_q.delete();
    end else begin
      if (pop && !empty) begin
        if (geometry_q.size() == 0) begin
          $display("%0t: result expected none got %h", $time, result);
          fail_count++;
        end else begin
          want = geometry_q.pop_front();
          check_field("status", want.status, result.status);
          check_field("fat_kind", want.fat_kind, result.fat_kind);
          check_field("bytes_per_sector", want.bytes_per_sector, result.bytes_per_sector);
          check_field("sectors_per_cluster", want.sectors_per_cluster,
                      result.sectors_per_cluster);
          check_field("root_entry_count", want.root_entry_count, result.root_entry_count);
          check_field("fat_start_sector", want.fat_start_sector, result.fat_start_sector);
          check_field("sectors_per_fat_table", want.sectors_per_fat_table,
                      result.sectors_per_fat_table);
          check_field("fat_copies", want.fat_copies, result.fat_copies);
          check_field("root_dir_sector", want.root_dir_sector, result.root_dir_sector);
          check_field("cluster0_sector", want.cluster0_sector, result.cluster0_sector);
          check_field("max_cluster", want.max_cluster, result.max_cluster);
        end
      end
      if (push && !full) take_byte(item);
    end
    waiting = geometry_q.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the FAT boot sector geometry unit: clock, reset, sector
// stimulus and random pop stalls; the verdict comes from fbsg_checker.
// Depends on fbsg_pkg, fbsg_checker and fat_boot_sector_geometry_unit.
module tb;
  import fbsg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SECTOR_BYTES = 512;
  localparam int MIN_WORDS    = 850;  // input words before the random part may stop
  localparam int MIN_SECTORS  = 48;   // results before the random part may stop
  localparam int CALM_SECTORS = 44;   // from here on neither side idles

  // How the signature area of a built sector is filled
  typedef enum {
    SIG_NONE,       // both texts broken
    SIG_FAT12,      // "FAT12"
    SIG_FAT16,      // "FAT16"
    SIG_FAT32,      // "FAT32" with a near miss on "FAT1"
    SIG_BAD_DIGIT,  // "FAT1" plus a wrong digit, "FAT32" also present
    SIG_BOTH        // "FAT12"/"FAT16" and "FAT32" both present
  } sig_kind_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  in_item_t item = '0;
  logic     full, empty;
  result_t  result;
  int       fail_count, waiting;

  logic [7:0] sec [SECTOR_BYTES];  // sector image being sent
  int   sector_pos  = 0;           // where the unit thinks it is in the sector
  int   words_sent  = 0;
  int   sectors_due = 0;           // sectors completed, i.e. results caused
  bit   calm        = 1'b0;        // no idling on either side

  always #1 clk = ~clk;

  fat_boot_sector_geometry_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  fbsg_checker #(.SECTOR_BYTES(SECTOR_BYTES)) geometry_check (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  // ---------------------------------------------------------------------
  // Input side. Everything here runs from a falling edge; a word counts
  // as taken at the first rising edge where push is high and full is low.
  // ---------------------------------------------------------------------

  // Push low while idling; the payload carries junk meanwhile, which the
  // unit must ignore.
  task automatic idle(int n);
    push <= 1'b0;
    item <= '{sector_byte: 8'($urandom), start_req: 1'($urandom)};
    repeat (n) @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b, logic s);
    int idx;
    if (!calm && $urandom_range(0, 11) == 0) idle($urandom_range(1, 6));
    item <= '{sector_byte: b, start_req: s};
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
    // mirror the unit's byte counter so later sectors know whether to
    // raise start_req
    idx = s ? 0 : sector_pos;
    if (idx == SECTOR_BYTES - 1) begin
      sector_pos = 0;
      sectors_due++;
    end else begin
      sector_pos = idx + 1;
    end
    @(negedge clk);
  endtask

  // Send the first len bytes of sec. start_req goes with byte 0 when asked,
  // and always when the unit is not at a sector boundary; otherwise the
  // sector rides on the counter wrap.
  task automatic send_sector(bit use_start, int len);
    for (int i = 0; i < len; i++)
      send_byte(sec[i], (i == 0) && (use_start || sector_pos != 0));
  endtask

  task automatic put_fat1(logic [7:0] digit);
    sec[OFF_SHORT_SIG]     = CH_F;
    sec[OFF_SHORT_SIG + 1] = CH_A;
    sec[OFF_SHORT_SIG + 2] = CH_T;
    sec[OFF_SHORT_SIG + 3] = CH_1;
    sec[OFF_SHORT_SIG + 4] = digit;
  endtask

  task automatic put_fat32();
    sec[OFF_LONG_SIG]     = CH_F;
    sec[OFF_LONG_SIG + 1] = CH_A;
    sec[OFF_LONG_SIG + 2] = CH_T;
    sec[OFF_LONG_SIG + 3] = CH_3;
    sec[OFF_LONG_SIG + 4] = CH_2;
  endtask

  // flip bits in one byte of a signature text: a near miss
  task automatic spoil(int base, int len);
    int k;
    k = base + $urandom_range(0, len - 1);
    sec[k] = sec[k] ^ 8'($urandom_range(1, 255));
  endtask

  task automatic build_sector(sig_kind_t sig, logic [15:0] bps, logic [7:0] spc,
                              logic [15:0] rsv, logic [7:0] copies,
                              logic [15:0] ents, logic [15:0] spf);
    logic [7:0] digit;
    for (int i = 0; i < SECTOR_BYTES; i++) sec[i] = 8'($urandom);
    sec[OFF_BPS_LO]  = bps[7:0];
    sec[OFF_BPS_HI]  = bps[15:8];
    sec[OFF_SPC]     = spc;
    sec[OFF_RSV_LO]  = rsv[7:0];
    sec[OFF_RSV_HI]  = rsv[15:8];
    sec[OFF_COPIES]  = copies;
    sec[OFF_ROOT_LO] = ents[7:0];
    sec[OFF_ROOT_HI] = ents[15:8];
    sec[OFF_SPF_LO]  = spf[7:0];
    sec[OFF_SPF_HI]  = spf[15:8];
    case (sig)
      SIG_FAT12: put_fat1(CH_2);
      SIG_FAT16: put_fat1(CH_6);
      SIG_FAT32: begin
        put_fat1(CH_2);
        spoil(OFF_SHORT_SIG, 4);
        put_fat32();
      end
      SIG_BAD_DIGIT: begin
        do digit = 8'($urandom); while (digit == CH_2 || digit == CH_6);
        put_fat1(digit);
        put_fat32();
      end
      SIG_BOTH: begin
        put_fat1($urandom_range(0, 1) ? CH_2 : CH_6);
        put_fat32();
      end
      default: begin
        put_fat1(CH_6);
        spoil(OFF_SHORT_SIG, 4);
        put_fat32();
        spoil(OFF_LONG_SIG, 5);
      end
    endcase
  endtask

  // 16-bit field: extremes and small values often, full range otherwise
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'($urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick8();
    case ($urandom_range(0, 4))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'(1 << $urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_bps();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;   // zero sector size
      1:       return 16'hffff;
      2:       return 16'h0001;
      3, 4, 5: return 16'd512;
      6:       return 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_sector();
    sig_kind_t sig;
    int        r;
    r = $urandom_range(0, 99);
    if (r < 30)      sig = SIG_FAT12;
    else if (r < 60) sig = SIG_FAT16;
    else if (r < 72) sig = SIG_FAT32;
    else if (r < 80) sig = SIG_BAD_DIGIT;
    else if (r < 88) sig = SIG_BOTH;
    else             sig = SIG_NONE;
    build_sector(sig, pick_bps(), pick8(), pick16(), pick8(), pick16(), pick16());
  endtask

  // ---------------------------------------------------------------------
  // Result side: pop mostly high, with random stall bursts.
  // ---------------------------------------------------------------------
  initial begin
    int hold;
    hold = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        hold = $urandom_range(0, 5);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int r, k;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed sectors ---
    // classic 1.44M floppy layout, FAT12
    build_sector(SIG_FAT12, 16'd512, 8'd1, 16'd1, 8'd2, 16'd224, 16'd9);
    send_sector(1'b1, SECTOR_BYTES);
    // FAT16 volume streamed straight after, no start_req: counter wrap
    build_sector(SIG_FAT16, 16'd512, 8'd4, 16'd4, 8'd2, 16'd512, 16'd256);
    send_sector(1'b0, SECTOR_BYTES);
    // FAT32 only reports its type
    build_sector(SIG_FAT32, 16'd512, 8'd8, 16'd32, 8'd2, 16'd0, 16'd0);
    send_sector(1'b1, SECTOR_BYTES);
    // "FAT1" with a wrong digit wins over a good "FAT32": no signature
    build_sector(SIG_BAD_DIGIT, 16'd512, 8'd1, 16'd1, 8'd2, 16'd224, 16'd9);
    send_sector(1'b1, SECTOR_BYTES);
    // neither text matches
    build_sector(SIG_NONE, 16'd512, 8'd1, 16'd1, 8'd2, 16'd224, 16'd9);
    send_sector(1'b1, SECTOR_BYTES);
    // both texts good: the short one takes priority
    build_sector(SIG_BOTH, 16'd1024, 8'd2, 16'd6, 8'd1, 16'd64, 16'd20);
    send_sector(1'b0, SECTOR_BYTES);
    // zero sector size
    build_sector(SIG_FAT12, 16'd0, 8'd3, 16'd7, 8'd2, 16'd100, 16'd11);
    send_sector(1'b1, SECTOR_BYTES);
    // all-ones fields: root sector stays just within 24 bits, cluster cap
    build_sector(SIG_FAT16, 16'hffff, 8'hff, 16'hffff, 8'hff, 16'hffff, 16'hffff);
    send_sector(1'b1, SECTOR_BYTES);
    build_sector(SIG_FAT12, 16'hffff, 8'hff, 16'hffff, 8'hff, 16'hffff, 16'hffff);
    send_sector(1'b1, SECTOR_BYTES);
    // FAT12 cap: just below, then just above
    build_sector(SIG_FAT12, 16'd1, 8'd1, 16'd1, 8'd1, 16'd16, 16'd6129);
    send_sector(1'b1, SECTOR_BYTES);
    build_sector(SIG_FAT12, 16'd1, 8'd1, 16'd1, 8'd1, 16'd16, 16'd6132);
    send_sector(1'b0, SECTOR_BYTES);
    // FAT16 cap: just below, then just above
    build_sector(SIG_FAT16, 16'd2, 8'd1, 16'd1, 8'd1, 16'd16, 16'd65526);
    send_sector(1'b1, SECTOR_BYTES);
    build_sector(SIG_FAT16, 16'd2, 8'd1, 16'd1, 8'd1, 16'd16, 16'd65527);
    send_sector(1'b1, SECTOR_BYTES);
    // cluster 0 ahead of sector 0: wraps below zero
    build_sector(SIG_FAT16, 16'd1, 8'd255, 16'd0, 8'd0, 16'd0, 16'd0);
    send_sector(1'b1, SECTOR_BYTES);
    // root sectors rounded up
    build_sector(SIG_FAT12, 16'd512, 8'd1, 16'd2, 8'd2, 16'd17, 16'd3);
    send_sector(1'b1, SECTOR_BYTES);
    // restart mid sector: the partial one must leave no trace
    build_sector(SIG_FAT16, 16'hffff, 8'hff, 16'hffff, 8'hff, 16'hffff, 16'hffff);
    send_sector(1'b1, 300);
    build_sector(SIG_FAT12, 16'd512, 8'd2, 16'd1, 8'd2, 16'd112, 16'd2);
    send_sector(1'b1, SECTOR_BYTES);

    // --- random part ---
    // Mostly whole sectors with random content; the rest are sectors cut
    // short and plain noise with stray start_req.
    while (words_sent < MIN_WORDS || sectors_due < MIN_SECTORS) begin
      calm = (words_sent >= MIN_WORDS) && (sectors_due >= CALM_SECTORS);
      r = $urandom_range(0, 99);
      random_sector();
      if (r < 75) begin
        send_sector($urandom_range(0, 6) != 0, SECTOR_BYTES);
      end else if (r < 88) begin
        send_sector(1'($urandom_range(0, 1)), $urandom_range(1, SECTOR_BYTES - 1));
      end else begin
        k = $urandom_range(1, 40);
        repeat (k) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
      end
    end

    // --- drain ---
    calm = 1'b1;
    push <= 1'b0;
    for (k = 0; k < 5000 && waiting != 0; k++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (waiting != 0) $display("%0t: %0d results never arrived", $time, waiting);
    if (fail_count == 0 && waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== fat_boot_sector_geometry_unit.f =====
sv/fbsg_pkg.sv
sv/fbsg_front.sv
sv/fbsg_queue.sv
sv/fbsg_back.sv
sv/fat_boot_sector_geometry_unit.sv
sim/fbsg_checker.sv
sim/tb.sv
